@@ hdl/memory_watch_range_table_core_defines.svh @@
// Assertion macros for the watch range table core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MEMORY_WATCH_RANGE_TABLE_CORE_DEFINES_SVH
`define MEMORY_WATCH_RANGE_TABLE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MWRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwrt assertion failed");
`define MWRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwrt assertion failed");
`else
`define MWRT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MWRT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/mwrt_pkg.sv @@
// Shared types and codes for the watch range table core.
// No dependencies; imported by mwrt_match and the core module.
`default_nettype none

package mwrt_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam logic [2:0] ACT_INSERT      = 3'd0;
    localparam logic [2:0] ACT_REMOVE_BASE = 3'd1;
    localparam logic [2:0] ACT_REMOVE_ID   = 3'd2;
    localparam logic [2:0] ACT_REMOVE_ALL  = 3'd3;
    localparam logic [2:0] ACT_FIND_BASE   = 3'd4;
    localparam logic [2:0] ACT_FIND_ID     = 3'd5;
    localparam logic [2:0] ACT_CHECK       = 3'd6;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] address;
        logic [31:0] region_length;
        logic [1:0]  access_kind;
        logic [15:0] target_id;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] result_id;
        logic [31:0] result_base;
        logic [31:0] result_length;
        logic [1:0]  result_kind;
        logic [4:0]  entry_count;
    } result_t;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] len;
        logic [1:0]  kind;
        logic [15:0] id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

@@ hdl/mwrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mwrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/mwrt_match.sv @@
// Shared compare unit: tests one table entry against the current key.
// Depends on mwrt_pkg (entry type, action codes).
`default_nettype none

module mwrt_match import mwrt_pkg::*; (
    input  logic [2:0]  mode,
    input  logic [31:0] key_addr,
    input  logic [15:0] key_id,
    input  entry_t      entry,
    output logic        hit
);

    logic [31:0] reach;

    always_comb
    begin
        // end of region wraps mod 2^32, so a wrapping region never hits
        reach = entry.base + entry.len;
        case (mode)
            ACT_REMOVE_BASE, ACT_FIND_BASE: hit = (entry.base == key_addr);
            ACT_REMOVE_ID, ACT_FIND_ID:     hit = (entry.id == key_id);
            ACT_CHECK:                      hit = (key_addr >= entry.base) && (key_addr < reach);
            default:                        hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/memory_watch_range_table_core.sv @@
// Watch range table core: ordered table of watch regions with a scan sequencer.
// Depends on mwrt_pkg, mwrt_ram, mwrt_match and the assertion macro header.
//
// Usage:
//   item/item_valid/item_stall carries one operation (insert, remove by base or
//   id, remove all, find by base or id, check address). result/result_valid/
//   result_stall returns exactly one result per operation, in order.
//   One operation is in flight at a time; item_stall is high from the transfer
//   until its result has been loaded into the output register.
//   Insert, remove all, unused codes, an empty table, check of 0: no scan.
//   Find and check: one table entry per cycle through the table RAM read port
//   and the single compare unit.
//   Remove: the scan up to the match, then the entries behind the match move up
//   one slot per cycle on the same read port.
//   Reset empties the table and clears the id counter; no clearing pass runs,
//   entries beyond the fill count are never compared or moved.
//   When the receiver stalls, the result holds in the output register and the
//   core waits with the next result before taking another item.
`default_nettype none
`include "memory_watch_range_table_core_defines.svh"

module memory_watch_range_table_core import mwrt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    item_valid,
    output logic    item_stall,
    output result_t result,
    output logic    result_valid,
    input  logic    result_stall
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       op_reg, op_next;
    logic [31:0]      key_addr_reg, key_addr_next;
    logic [15:0]      key_id_reg, key_id_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      next_id_reg, next_id_next;
    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             wr_valid_reg, wr_valid_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    result_t          res_reg, res_next;
    result_t          out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             item_accept;
    logic             out_load;
    logic             hit;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;
    logic [15:0]      id_bump;
    logic [CNT_W-1:0] issue_dec;
    logic [CNT_W+4:0] count_wide;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_accept  = item_valid & ~item_stall;
    assign out_load     = (state_reg == S_DONE) && (!out_valid_reg || !result_stall);
    assign id_bump      = (next_id_reg == 16'hFFFF) ? 16'd1 : next_id_reg + 16'd1;
    assign issue_dec    = issue_idx_reg - 1'b1;
    assign count_wide   = {5'b0, count_reg};
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    mwrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mwrt_match u_match (
        .mode     (op_reg),
        .key_addr (key_addr_reg),
        .key_id   (key_id_reg),
        .entry    (ram_rdata),
        .hit      (hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_addr_next  = key_addr_reg;
        key_id_next    = key_id_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        issue_idx_next = issue_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        wr_valid_next  = wr_valid_reg;
        wr_idx_next    = wr_idx_reg;
        res_next       = res_reg;

        ram_we         = 1'b0;
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_raddr      = issue_idx_reg[IDX_W-1:0];
        ram_wdata.base = item.address;
        ram_wdata.len  = item.region_length;
        ram_wdata.kind = item.access_kind;
        ram_wdata.id   = id_bump;

        case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    op_next        = item.action;
                    key_addr_next  = item.address;
                    key_id_next    = item.target_id;
                    res_next       = '0;
                    issue_idx_next = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = S_DONE;
                    case (item.action)
                        ACT_INSERT:
                        begin
                            if (count_reg != FULL_CNT)
                            begin
                                ram_we             = 1'b1;
                                count_next         = count_reg + 1'b1;
                                next_id_next       = id_bump;
                                res_next.ok        = 1'b1;
                                res_next.result_id = id_bump;
                            end
                        end
                        ACT_REMOVE_ALL:
                        begin
                            res_next.ok = (count_reg != '0);
                            count_next  = '0;
                        end
                        ACT_REMOVE_BASE, ACT_REMOVE_ID, ACT_FIND_BASE, ACT_FIND_ID:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_CHECK:
                        begin
                            // address zero never hits
                            if (count_reg != '0 && item.address != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next.ok = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read issued in the cycle before the compare
                if (cmp_valid_reg && hit)
                begin
                    case (op_reg)
                        ACT_FIND_BASE, ACT_FIND_ID:
                        begin
                            res_next.ok            = 1'b1;
                            res_next.result_id     = ram_rdata.id;
                            res_next.result_base   = ram_rdata.base;
                            res_next.result_length = ram_rdata.len;
                            res_next.result_kind   = ram_rdata.kind;
                            state_next             = S_DONE;
                        end
                        ACT_CHECK:
                        begin
                            res_next.ok        = 1'b1;
                            res_next.result_id = ram_rdata.id;
                            state_next         = S_DONE;
                        end
                        default:
                        begin
                            issue_idx_next = cmp_idx_reg + 1'b1;
                            wr_valid_next  = 1'b0;
                            state_next     = S_SHIFT;
                        end
                    endcase
                end
                else if (cmp_valid_reg && (cmp_idx_reg + 1'b1 == count_reg))
                begin
                    state_next = S_DONE;
                end
                else if (issue_idx_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_idx_reg;
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
            end

            S_SHIFT:
            begin
                // entry read last cycle moves up one slot
                if (wr_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_idx_reg;
                    ram_wdata = ram_rdata;
                end
                if (issue_idx_reg < count_reg)
                begin
                    wr_valid_next  = 1'b1;
                    wr_idx_next    = issue_dec[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                else
                begin
                    wr_valid_next = 1'b0;
                    if (!wr_valid_reg)
                    begin
                        count_next  = count_reg - 1'b1;
                        res_next.ok = 1'b1;
                        state_next  = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next             = res_reg;
        out_next.entry_count = count_wide[4:0];
        out_valid_next       = out_load | (out_valid_reg & result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            next_id_reg   <= '0;
            issue_idx_reg <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            wr_valid_reg  <= 1'b0;
            wr_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            issue_idx_reg <= issue_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            wr_valid_reg  <= wr_valid_next;
            wr_idx_reg    <= wr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_addr_reg <= key_addr_next;
        key_id_reg   <= key_id_next;
        res_reg      <= res_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    `MWRT_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `MWRT_ASSERT_IMP(a_write_src, clk, rst_n, ram_we, item_accept || state_reg == S_SHIFT)
    `MWRT_ASSERT_IMP(a_scan_range, clk, rst_n, state_reg == S_SCAN && cmp_valid_reg, cmp_idx_reg < count_reg)
    `MWRT_ASSERT_NXT(a_insert_count, clk, rst_n, item_accept && item.action == ACT_INSERT && count_reg != FULL_CNT, count_reg == $past(count_reg) + 1'b1)
    `MWRT_ASSERT_NXT(a_done_load, clk, rst_n, out_load, out_valid_reg && state_reg == S_IDLE)

endmodule

`default_nettype wire
